/* rtl/gptw_pkg.sv */
package gptw_pkg;

  // Virtual address bits covered by the two-level table
  localparam int VA_BITS = 40;

  localparam logic [63:0] ADDR_MASK = 64'h0000_00FF_FFFF_F000;
  localparam logic [12:0] PAGE_SIZE = 13'h1000;

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Input word kinds
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // Result kinds
  localparam logic [1:0] RK_READ  = 2'd0;
  localparam logic [1:0] RK_CHUNK = 2'd1;
  localparam logic [1:0] RK_FAULT = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_START_PAGE = 3'd0;
  localparam logic [2:0] CFG_BASE_PAGE  = 3'd1;
  localparam logic [2:0] CFG_DEPTH      = 3'd2;
  localparam logic [2:0] CFG_BLOCK_SIZE = 3'd3;
  localparam logic [2:0] CFG_FB_LOC     = 3'd4;
  localparam logic [2:0] CFG_FB_OFFSET  = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PDE  = 2'd1,
    PH_PTE2 = 2'd2,
    PH_PTE1 = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] virt_address;
    logic [31:0] byte_count;
    logic        probe_only;
    logic [63:0] entry;
    logic        read_failed;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] out_address;
    logic [12:0] chunk_length;
    logic        system_page;
    logic        mapped;
    logic        done_res;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [31:0] table_start_page;
    logic [31:0] table_base_page;
    logic        table_depth;
    logic [3:0]  block_size;
    logic [15:0] fb_location;
    logic [15:0] fb_offset;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] current_address;
    logic [31:0] bytes_left;
    logic        probe_mode;
    logic [39:0] pte_table_base;
  } walk_t;

  typedef struct packed {
    logic [1:0] count;
    res_word_t  r0;
    res_word_t  r1;
    walk_t      walk_next;
  } step_t;

endpackage

/* rtl/gptw_step.sv */
module gptw_step
  import gptw_pkg::*;
(
  input  req_word_t word,
  input  walk_t     walk,
  input  cfg_t      cfg,
  output step_t     step
);

  logic [63:0] fb_base;
  logic [63:0] fb_off;
  logic [63:0] tbl_base;
  logic [63:0] ca_new;
  logic [11:0] off;
  logic [32:0] span;
  logic [12:0] len;
  logic [31:0] bl_after;
  logic [63:0] ca_after;
  logic [63:0] rd_ca;
  int          pde_w;
  logic [5:0]  pde_shift;
  logic [63:0] pde_idx;
  logic [63:0] rd_addr;
  phase_t      rd_phase;
  logic [39:0] pte_base;
  logic [63:0] pte2_idx;
  logic [63:0] pte2_addr;
  logic [63:0] pte_phys;
  logic        sys;
  res_word_t   fault_w;

  assign fb_base  = {24'b0, cfg.fb_location, 24'b0};
  assign fb_off   = {26'b0, cfg.fb_offset, 22'b0};
  assign tbl_base = {20'b0, cfg.table_base_page, 12'b0};
  assign ca_new   = word.virt_address - {20'b0, cfg.table_start_page, 12'b0};

  // Chunk length: the page offset of the physical address equals that of
  // the virtual one, since every term added is page aligned.
  assign off      = walk.current_address[11:0];
  assign span     = {21'b0, off} + {1'b0, walk.bytes_left};
  assign len      = (|span[32:12]) ? (PAGE_SIZE - {1'b0, off}) : walk.bytes_left[12:0];
  assign bl_after = walk.bytes_left - {19'b0, len};
  assign ca_after = walk.current_address + {51'b0, len};

  // Next table read, either for a new request or after a chunk
  assign rd_ca     = (word.kind == KIND_REQ) ? ca_new : ca_after;
  assign pde_w     = VA_BITS - 21 - int'(cfg.block_size);
  assign pde_shift = 6'd21 + {2'b0, cfg.block_size};

  always_comb begin
    pde_idx = '0;
    if (pde_w > 0) begin
      pde_idx = (rd_ca >> pde_shift) & ((64'd1 << pde_w) - 64'd1);
    end
    if (cfg.table_depth) begin
      rd_addr  = tbl_base + (pde_idx << 3) - fb_base;
      rd_phase = PH_PDE;
    end else begin
      rd_addr  = tbl_base + {9'b0, rd_ca[63:12], 3'b0} - fb_base;
      rd_phase = PH_PTE1;
    end
  end

  assign pte_base  = word.entry[39:0] & ADDR_MASK[39:0];
  assign pte2_idx  = (walk.current_address >> 12)
                   & ((64'd1 << (5'd9 + {1'b0, cfg.block_size})) - 64'd1);
  assign pte2_addr = {24'b0, pte_base} + (pte2_idx << 3) - fb_base;

  assign sys = word.entry[1];
  always_comb begin
    pte_phys = {24'b0, pte_base[39:12], 12'b0} + {52'b0, off};
    if (walk.phase == PH_PTE2 && !sys) begin
      pte_phys = pte_phys - fb_off;
    end
  end

  always_comb begin
    fault_w = '0;
    fault_w.result_kind = RK_FAULT;
    fault_w.out_address = walk.current_address;
    fault_w.done_res    = 1'b1;
    fault_w.last        = 1'b1;
  end

  always_comb begin
    step = '0;
    step.walk_next = walk;

    if (word.kind == KIND_REQ) begin
      step.count                     = 2'd1;
      step.walk_next.current_address = ca_new;
      step.walk_next.bytes_left      = word.byte_count;
      step.walk_next.probe_mode      = word.probe_only;
      step.walk_next.phase           = rd_phase;
      step.r0.result_kind            = RK_READ;
      step.r0.out_address            = rd_addr;
      step.r0.last                   = 1'b1;
    end else if (walk.phase == PH_IDLE) begin
      step.count = 2'd0;
    end else if (word.read_failed ||
                 (!word.entry[0] && !walk.probe_mode)) begin
      step.count           = 2'd1;
      step.r0              = fault_w;
      step.walk_next.phase = PH_IDLE;
    end else if (walk.phase == PH_PDE && word.entry[0]) begin
      step.count                    = 2'd1;
      step.walk_next.pte_table_base = pte_base;
      step.walk_next.phase          = PH_PTE2;
      step.r0.result_kind           = RK_READ;
      step.r0.out_address           = pte2_addr;
      step.r0.last                  = 1'b1;
    end else begin
      // Chunk: a PTE (valid, or invalid in probe mode), or a skipped page behind an invalid PDE in probe mode
      step.walk_next.current_address = ca_after;
      step.walk_next.bytes_left      = bl_after;
      step.r0.result_kind            = RK_CHUNK;
      step.r0.chunk_length           = len;
      if (walk.phase != PH_PDE) begin
        step.r0.out_address = pte_phys;
        step.r0.system_page = sys;
        step.r0.mapped      = 1'b1;
      end
      if (bl_after == '0) begin
        step.count           = 2'd1;
        step.r0.done_res     = 1'b1;
        step.r0.last         = 1'b1;
        step.walk_next.phase = PH_IDLE;
      end else begin
        step.count           = 2'd2;
        step.walk_next.phase = rd_phase;
        step.r1.result_kind  = RK_READ;
        step.r1.out_address  = rd_addr;
        step.r1.last         = 1'b1;
      end
    end
  end

endmodule

/* rtl/gptw_oq.sv */
module gptw_oq
  import gptw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  res_word_t  push0,
  input  res_word_t  push1,
  input  logic       pop,
  output res_word_t  head,
  output logic       not_empty,
  output logic       room
);

  res_word_t           mem [OQ_DEPTH];
  logic [OQ_AW-1:0]    wr_ptr;
  logic [OQ_AW-1:0]    rd_ptr;
  logic [OQ_CW-1:0]    count;
  logic [OQ_CW-1:0]    count_next;
  logic                do_pop;

  assign do_pop     = pop && not_empty;
  assign count_next = count + OQ_CW'(push_count) - OQ_CW'(do_pop);
  assign not_empty  = (count != '0);
  // room for the two words one step can produce
  assign room       = (count <= OQ_CW'(OQ_DEPTH - 2));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push_count);
      rd_ptr <= rd_ptr + OQ_AW'(do_pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + OQ_AW'(1)] <= push1;
    end
  end

endmodule

/* rtl/gpu_page_table_walker_top.sv */
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_stall  req_word_t  (request or table entry)
// res      out        res_valid / res_stall  res_word_t  (read, chunk or fault)
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word is held in the input register and decoded there in a single
// step; its one or two results land in a four-entry output queue and show up
// in the next cycle. One word per cycle while the queue holds two words or fewer;
// each two-result step leaves one more word queued than the output drains, so
// the input stalls once more than two are waiting, even with the output free.
// Synchronous reset clears the walk state, the queue pointers and the registers.
module gpu_page_table_walker_top
  import gptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        res_valid,
  input  logic        res_stall,
  output res_word_t   res_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  walk_t     walk;
  logic      pipe_valid;
  req_word_t pipe_word;
  step_t     step;
  logic      room;
  logic      go;
  logic      req_take;

  assign cfg_ready = 1'b1;
  assign go        = pipe_valid && room;
  assign req_stall = pipe_valid && !room;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_PAGE: cfg.table_start_page <= cfg_data;
        CFG_BASE_PAGE:  cfg.table_base_page  <= cfg_data;
        CFG_DEPTH:      cfg.table_depth      <= cfg_data[0];
        CFG_BLOCK_SIZE: cfg.block_size       <= cfg_data[3:0];
        CFG_FB_LOC:     cfg.fb_location      <= cfg_data[15:0];
        CFG_FB_OFFSET:  cfg.fb_offset        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= req_take || (pipe_valid && !go);
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      pipe_word <= req_word;
    end
  end

  gptw_step u_step (
    .word (pipe_word),
    .walk (walk),
    .cfg  (cfg),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (go) begin
      walk <= step.walk_next;
    end
  end

  gptw_oq u_oq (
    .clk        (clk),
    .rst        (rst),
    .push_count (go ? step.count : 2'd0),
    .push0      (step.r0),
    .push1      (step.r1),
    .pop        (!res_stall),
    .head       (res_word),
    .not_empty  (res_valid),
    .room       (room)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (go && step.count != 2'd0) |=> res_valid)
    else $error("queued result not presented");

  a_idle_resp_quiet: assert property (@(posedge clk) disable iff (rst)
    (go && pipe_word.kind == KIND_RESP && walk.phase == PH_IDLE) |-> step.count == 2'd0)
    else $error("response while idle produced a result");

  a_fault_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.result_kind == RK_FAULT) |-> (res_word.done_res && res_word.last))
    else $error("fault word without done and last");

  a_fault_idles: assert property (@(posedge clk) disable iff (rst)
    (go && step.count == 2'd1 && step.r0.result_kind == RK_FAULT) |=> walk.phase == PH_IDLE)
    else $error("walk still busy after fault");
`endif

endmodule

/* sim/gpu_page_table_walker_top_tb.sv */
`timescale 1ns / 100ps

module gpu_page_table_walker_top_tb;
  import gptw_pkg::*;

  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 150;

  typedef struct packed {
    logic      is_regs;
    logic      fixed;
    cfg_t      setting;
    req_word_t word;
    res_word_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_word_t   req_word;
  logic        res_valid;
  logic        res_stall;
  res_word_t   res_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // shadow of the walker: registers and walk state
  cfg_t        shadow_cfg;
  phase_t      walk_phase;
  logic [63:0] walk_va;
  logic [31:0] walk_left;
  logic        walk_probe;
  logic [39:0] walk_pte_base;
  res_word_t   pending_res[$];

  logic gaps_on     = 1'b1;
  logic stalls_on   = 1'b1;
  logic long_hold   = 1'b0;
  int   fail_count  = 0;
  int   idle_cycles = 0;

  gpu_page_table_walker_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic res_word_t mk_res(logic [1:0] k, logic [63:0] a, logic [12:0] n,
                                       logic s, logic m, logic d, logic l);
    return {k, a, n, s, m, d, l};
  endfunction

  function automatic req_word_t mk_req(logic [63:0] va, logic [31:0] n, logic probe);
    return {KIND_REQ, va, n, probe, 64'd0, 1'b0};
  endfunction

  function automatic req_word_t mk_resp(logic [63:0] e, logic failed);
    return {KIND_RESP, 64'd0, 32'd0, 1'b0, e, failed};
  endfunction

  function automatic cfg_t mk_cfg(logic [31:0] start, logic [31:0] base, logic depth,
                                  logic [3:0] bs, logic [15:0] loc, logic [15:0] off);
    return {start, base, depth, bs, loc, off};
  endfunction

  function automatic plan_row_t word_row(req_word_t w, logic fixed, res_word_t want);
    plan_row_t r;
    r = '0;
    r.word  = w;
    r.fixed = fixed;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t regs_row(cfg_t c);
    plan_row_t r;
    r = '0;
    r.is_regs = 1'b1;
    r.setting = c;
    return r;
  endfunction

  function automatic logic [63:0] fb_base();
    return {24'd0, shadow_cfg.fb_location, 24'd0};
  endfunction

  // address of the next table entry for walk_va; moves the walk to that level
  function automatic logic [63:0] next_table_read();
    logic [63:0] base;
    logic [63:0] idx;
    int          w;
    base = {20'd0, shadow_cfg.table_base_page, 12'd0};
    idx  = '0;
    if (shadow_cfg.table_depth) begin
      w = VA_BITS - 21 - int'(shadow_cfg.block_size);
      if (w > 0) begin
        idx = (walk_va >> (21 + shadow_cfg.block_size)) & ((64'd1 << w) - 64'd1);
      end
      walk_phase = PH_PDE;
    end else begin
      idx = walk_va >> 12;
      walk_phase = PH_PTE1;
    end
    return base + (idx << 3) - fb_base();
  endfunction

  function automatic void raise_fault();
    pending_res.push_back(mk_res(RK_FAULT, walk_va, 13'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    walk_phase = PH_IDLE;
  endfunction

  // one page-bounded chunk, then the next table read if bytes remain
  function automatic void emit_chunk(logic [63:0] phys, logic sys, logic map,
                                     logic [63:0] addr_out);
    logic [63:0] off;
    logic [31:0] len;
    off = phys & 64'hFFF;
    if (((off + {32'd0, walk_left}) & ~64'hFFF) != 64'd0) begin
      len = 32'h1000 - off[31:0];
    end else begin
      len = walk_left;
    end
    walk_left = walk_left - len;
    walk_va   = walk_va + {32'd0, len};
    if (walk_left == 32'd0) begin
      pending_res.push_back(mk_res(RK_CHUNK, addr_out, len[12:0], sys, map, 1'b1, 1'b1));
      walk_phase = PH_IDLE;
    end else begin
      pending_res.push_back(mk_res(RK_CHUNK, addr_out, len[12:0], sys, map, 1'b0, 1'b0));
      pending_res.push_back(mk_res(RK_READ, next_table_read(), 13'd0, 1'b0, 1'b0, 1'b0,
                                   1'b1));
    end
  endfunction

  function automatic void walk_step(req_word_t w);
    logic [63:0] idx;
    logic [63:0] phys;
    logic        sys;
    if (w.kind == KIND_REQ) begin
      walk_va    = w.virt_address - {20'd0, shadow_cfg.table_start_page, 12'd0};
      walk_left  = w.byte_count;
      walk_probe = w.probe_only;
      pending_res.push_back(mk_res(RK_READ, next_table_read(), 13'd0, 1'b0, 1'b0, 1'b0,
                                   1'b1));
      return;
    end
    if (walk_phase == PH_IDLE) return;
    if (w.read_failed) begin
      raise_fault();
      return;
    end
    if (walk_phase == PH_PDE) begin
      if (!w.entry[0]) begin
        // probe mode skips an unmapped directory entry to the next page
        if (!walk_probe) raise_fault();
        else emit_chunk(walk_va & 64'hFFF, 1'b0, 1'b0, 64'd0);
        return;
      end
      walk_pte_base = w.entry[39:0] & ADDR_MASK[39:0];
      walk_phase    = PH_PTE2;
      idx = (walk_va >> 12) & ((64'd1 << (9 + shadow_cfg.block_size)) - 64'd1);
      pending_res.push_back(mk_res(RK_READ, {24'd0, walk_pte_base} + (idx << 3) - fb_base(),
                                   13'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      return;
    end
    if (!w.entry[0] && !walk_probe) begin
      raise_fault();
      return;
    end
    sys  = w.entry[1];
    phys = (w.entry & ADDR_MASK) + (walk_va & 64'hFFF);
    if (walk_phase == PH_PTE2 && !sys) phys = phys - {26'd0, shadow_cfg.fb_offset, 22'd0};
    emit_chunk(phys, sys, 1'b1, phys);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_word(input req_word_t w);
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
    walk_step(w);
  endtask

  task automatic sender_gap();
    int n;
    n = gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait for every awaited word, then let ignored words clear the pipe
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    logic [2:0]  idx[6];
    logic [31:0] vals[6];
    idx  = '{CFG_START_PAGE, CFG_BASE_PAGE, CFG_DEPTH, CFG_BLOCK_SIZE, CFG_FB_LOC,
             CFG_FB_OFFSET};
    // unused upper bits carry noise; the block keeps only the register width
    vals = '{c.table_start_page, c.table_base_page, {31'($urandom), c.table_depth},
             {28'($urandom), c.block_size}, {16'($urandom), c.fb_location},
             {16'($urandom), c.fb_offset}};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    shadow_cfg = c;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        $error("result word with nothing awaited: %h", res_word);
        fail_count++;
      end else begin
        want = pending_res.pop_front();
        check_field("result_kind", want.result_kind, res_word.result_kind);
        check_field("out_address", want.out_address, res_word.out_address);
        check_field("chunk_length", want.chunk_length, res_word.chunk_length);
        check_field("system_page", want.system_page, res_word.system_page);
        check_field("mapped", want.mapped, res_word.mapped);
        check_field("done_res", want.done_res, res_word.done_res);
        check_field("last", want.last, res_word.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gpu_page_table_walker_top regression: fail");
      $finish;
    end
  end

  initial begin : result_sink
    int n;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // long back-pressure so the output queue fills and the input stalls
        long_hold = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        n = pick_gap();
        if (n > 0) begin
          res_stall <= 1'b1;
          repeat (n) @(posedge clk);
          res_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    req_word_t w;
    cfg_t      c;
    int        counted;
    int        pick;

    rst           = 1'b1;
    req_valid     = 1'b0;
    req_word      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_START_PAGE;
    cfg_data      = '0;
    shadow_cfg    = '0;
    walk_phase    = PH_IDLE;
    walk_va       = '0;
    walk_left     = '0;
    walk_probe    = 1'b0;
    walk_pte_base = '0;

    // one-level walks under the reset registers
    plan.push_back(word_row(mk_resp(64'h0000_00AB_CDEF_1001, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_req(64'd0, 32'd0, 1'b0), 1'b1,
                            mk_res(RK_READ, 64'd0, 13'd0, 1'b0, 1'b0, 1'b0, 1'b1)));
    plan.push_back(word_row(mk_resp(64'h3, 1'b0), 1'b1,
                            mk_res(RK_CHUNK, 64'd0, 13'd0, 1'b1, 1'b1, 1'b1, 1'b1)));
    plan.push_back(word_row(mk_req('1, '1, 1'b1), 1'b1,
                            mk_res(RK_READ, 64'h007F_FFFF_FFFF_FFF8, 13'd0, 1'b0, 1'b0,
                                   1'b0, 1'b1)));
    plan.push_back(word_row(mk_resp(64'd0, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h0000_0012_3456_7001, 1'b1), 1'b1,
                            mk_res(RK_FAULT, 64'd0, 13'd0, 1'b0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(word_row(mk_resp(64'h1, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_req(64'h1234_5678, 32'h2000, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'hFFFF_FFFF_FFFF_FFFE, 1'b0), 1'b1,
                            mk_res(RK_FAULT, 64'h1234_5678, 13'd0, 1'b0, 1'b0, 1'b1,
                                   1'b1)));
    plan.push_back(word_row(mk_req(64'hFF0, 32'h20, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'hFFFF_FFFF_FFFF_FFFD, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h0000_0012_3456_7003, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_req(64'h0000_3C00_0000_0A00, 32'h5000, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h0000_00AB_CDEF_0001, 1'b0), 1'b0, '0));
    // new request abandons the walk in flight
    plan.push_back(word_row(mk_req(64'h7FFF_FFFF_FFFF_F000, 32'h1, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h0000_0000_0055_5001, 1'b0), 1'b0, '0));
    // two-level walks
    plan.push_back(regs_row(mk_cfg(32'd0, 32'h10, 1'b1, 4'h0, 16'h0, 16'h1)));
    plan.push_back(word_row(mk_req(64'h40_0123, 32'h10, 1'b1), 1'b1,
                            mk_res(RK_READ, 64'h1_0010, 13'd0, 1'b0, 1'b0, 1'b0, 1'b1)));
    plan.push_back(word_row(mk_resp(64'd0, 1'b0), 1'b1,
                            mk_res(RK_CHUNK, 64'd0, 13'h10, 1'b0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(word_row(mk_req(64'h40_0123, 32'h10, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h10, 1'b0), 1'b1,
                            mk_res(RK_FAULT, 64'h40_0123, 13'd0, 1'b0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(word_row(mk_req(64'h40_0123, 32'h2000, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h20_0001, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h80_0001, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp('1, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'h8000_0000_0000_3003, 1'b0), 1'b0, '0));
    plan.push_back(regs_row(mk_cfg('1, '1, 1'b1, 4'hF, '1, '1)));
    plan.push_back(word_row(mk_req(64'h0123_4567_89AB_CDEF, 32'h3000, 1'b0), 1'b0, '0));
    plan.push_back(word_row(mk_resp(64'd0, 1'b1), 1'b0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_regs) begin
        drain();
        load_regs(plan[i].setting);
      end else begin
        send_word(plan[i].word);
        if (plan[i].fixed) begin
          void'(pending_res.pop_back());
          pending_res.push_back(plan[i].want);
        end
        sender_gap();
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: c = mk_cfg('1, '1, 1'b1, 4'hF, '1, '1);
        1: c = mk_cfg('0, '0, 1'b0, 4'h0, '0, '0);
        default: c = mk_cfg($urandom, $urandom, (p % 2 == 0) || ($urandom_range(0, 1) == 1),
                            4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
      endcase
      // a walk left pending here sees the new registers on its next entry
      drain();
      load_regs(c);
      gaps_on   = (p != 3);
      stalls_on = (p != 3);
      long_hold = (p == 2);
      counted   = 0;
      while (counted < PHASE_ITEMS) begin
        w.virt_address = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1) begin
          w.virt_address = {20'd0, shadow_cfg.table_start_page, 12'd0} +
                           {24'd0, 8'($urandom), $urandom};
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) w.byte_count = $urandom_range(0, 64);
        else if (pick < 80) w.byte_count = $urandom_range(0, 32'h3000);
        else if (pick < 95) w.byte_count = $urandom_range(0, 32'h2_0000);
        else w.byte_count = $urandom;
        w.probe_only  = ($urandom_range(0, 9) < 3);
        w.entry       = {$urandom, $urandom};
        w.read_failed = ($urandom_range(0, 1) == 1);
        if (walk_phase == PH_IDLE) begin
          w.kind = ($urandom_range(0, 9) == 0) ? KIND_RESP : KIND_REQ;
        end else begin
          w.kind = ($urandom_range(0, 99) < 8) ? KIND_REQ : KIND_RESP;
        end
        if (w.kind == KIND_RESP) begin
          w.entry[0]    = ($urandom_range(0, 9) != 0);
          w.read_failed = ($urandom_range(0, 39) == 0);
        end
        // responses while idle are dropped by the block and do not count
        if (!(w.kind == KIND_RESP && walk_phase == PH_IDLE)) counted++;
        send_word(w);
        if (p != 2 || counted > 60) sender_gap();
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gpu_page_table_walker_top regression: pass");
    end else begin
      $display("gpu_page_table_walker_top regression: fail");
    end
    $finish;
  end

endmodule
